/* rtl/core/external_interrupt_line_controller_core_macros.svh */
`ifndef EXTERNAL_INTERRUPT_LINE_CONTROLLER_CORE_MACROS_SVH
`define EXTERNAL_INTERRUPT_LINE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define EILC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EILC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/eilc_pkg.sv */
package eilc_pkg;

  localparam int LINE_COUNT = 8;
  localparam int PIN_W      = 8;
  localparam int DATA_W     = 32;
  localparam int NIBBLE_W   = 4;
  localparam int CODE_W     = 3;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    REG_CTRL = 2'd0,
    REG_MASK = 2'd1,
    REG_PEND = 2'd2
  } reg_sel_t;

  typedef enum logic [CODE_W-1:0] {
    TRIG_LOW  = 3'd0,
    TRIG_HIGH = 3'd1,
    TRIG_FALL = 3'd2,
    TRIG_RISE = 3'd3,
    TRIG_BOTH = 3'd4
  } trig_mode_t;

  typedef trig_mode_t [LINE_COUNT-1:0] mode_vec_t;
  typedef logic [LINE_COUNT-1:0] line_vec_t;

  typedef struct packed {
    func_t               func;
    reg_sel_t            sel;
    logic [DATA_W-1:0]   wdata;
    logic [PIN_W-1:0]    pins;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd_data;
    logic              irq;
  } rsp_t;

endpackage

/* rtl/core/eilc_trig.sv */
module eilc_trig
  import eilc_pkg::*;
(
  input  mode_vec_t mode,
  input  line_vec_t pins_now,
  input  line_vec_t pins_prev,
  output line_vec_t fire
);

  always_comb begin
    fire = '0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      case (mode[i])
        TRIG_LOW:  fire[i] = !pins_now[i];
        TRIG_HIGH: fire[i] = pins_now[i];
        TRIG_FALL: fire[i] = pins_prev[i] && !pins_now[i];
        TRIG_RISE: fire[i] = !pins_prev[i] && pins_now[i];
        TRIG_BOTH: fire[i] = pins_prev[i] != pins_now[i];
        default:   fire[i] = 1'b0;
      endcase
    end
  end

endmodule

/* rtl/core/eilc_regs.sv */
module eilc_regs
  import eilc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  req_t req,
  output rsp_t rsp,
  output logic irq_now
);

  mode_vec_t mode_r, mode_nxt;
  line_vec_t mask_r, mask_nxt;
  line_vec_t pend_r, pend_nxt;
  line_vec_t prev_r, prev_nxt;
  line_vec_t fire;
  line_vec_t pins_now;

  assign pins_now = req.pins[LINE_COUNT-1:0];

  eilc_trig u_trig (
    .mode      (mode_r),
    .pins_now  (pins_now),
    .pins_prev (prev_r),
    .fire      (fire)
  );

  always_comb begin
    mode_nxt    = mode_r;
    mask_nxt    = mask_r;
    pend_nxt    = pend_r;
    prev_nxt    = prev_r;
    rsp.rd_data = '0;
    unique case (req.func)
      FUNC_TICK: begin
        pend_nxt = pend_r | fire;
        prev_nxt = pins_now;
      end
      FUNC_READ: begin
        unique case (req.sel)
          REG_CTRL: begin
            for (int i = 0; i < LINE_COUNT; i++) begin
              rsp.rd_data[NIBBLE_W*i +: CODE_W] = mode_r[i];
            end
          end
          REG_MASK: rsp.rd_data = DATA_W'(mask_r);
          REG_PEND: rsp.rd_data = DATA_W'(pend_r);
          default:  rsp.rd_data = '0;
        endcase
      end
      FUNC_WRITE: begin
        unique case (req.sel)
          REG_CTRL: begin
            for (int i = 0; i < LINE_COUNT; i++) begin
              mode_nxt[i] = trig_mode_t'(req.wdata[NIBBLE_W*i +: CODE_W]);
            end
          end
          REG_MASK: mask_nxt = req.wdata[LINE_COUNT-1:0];
          // write one to clear
          REG_PEND: pend_nxt = pend_r & ~req.wdata[LINE_COUNT-1:0];
          default:  mask_nxt = mask_r;
        endcase
      end
      default: pend_nxt = pend_r;
    endcase
    rsp.irq = |(pend_nxt & ~mask_nxt);
  end

  assign irq_now = |(pend_r & ~mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '{default: TRIG_LOW};
      mask_r <= '1;
      pend_r <= '0;
      prev_r <= '0;
    end else if (en) begin
      mode_r <= mode_nxt;
      mask_r <= mask_nxt;
      pend_r <= pend_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

/* rtl/core/external_interrupt_line_controller_core.sv */
// interrupt controller for eight external lines, driven by one request channel
// in_*: one request per accepted item: func 0 samples in_pin_levels, 1 reads the
//   register named by in_reg_select, 2 writes in_write_data to it
//   (trigger control nibbles, mask bits, pending bits write-one-to-clear)
// out_*: one result per request: out_read_data holds the register on a read and
//   zero otherwise, out_irq_out is high when a pending line is unmasked after it
// path: an accepted request passes the input register, then the register update
//   and the result register, which load together when stage one advances
// throughput: one request per cycle while out_stall is low; the register file
//   updates in one pass of trigger and decode logic; only out_stall can hold it
// stall: a result held by out_stall keeps its register; one more request is
//   still taken into the input register, after which in_stall rises
// reset: synchronous, active low; all lines low-level trigger, all masked,
//   nothing pending, previous pins zero, both stages empty
`include "external_interrupt_line_controller_core_macros.svh"

module external_interrupt_line_controller_core
  import eilc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [1:0]        in_reg_select,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [PIN_W-1:0]  in_pin_levels,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_irq_out
);

  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r;
  logic s1_adv;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic irq_now;

  // stage one moves on when the result register is free or being emptied
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (!in_stall) s1_valid_nxt = in_valid;
    if (s1_adv) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r.func  <= func_t'(in_func);
      s1_req_r.sel   <= reg_sel_t'(in_reg_select);
      s1_req_r.wdata <= in_write_data;
      s1_req_r.pins  <= in_pin_levels;
    end
    if (s1_valid_r && s1_adv) begin
      out_rsp_r <= rsp;
    end
  end

  eilc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_valid_r && s1_adv),
    .req     (s1_req_r),
    .rsp     (rsp),
    .irq_now (irq_now)
  );

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rsp_r.rd_data;
  assign out_irq_out   = out_rsp_r.irq;

  `EILC_ASSERT_NOW(a_stall_only_when_full, in_stall,
    s1_valid_r && out_valid_r && out_stall, "input stalled with room in the pipe")
  `EILC_ASSERT_NEXT(a_nonread_zero, s1_valid_r && s1_adv && s1_req_r.func != FUNC_READ,
    out_read_data == '0, "nonzero read data on a non-read request")
  `EILC_ASSERT_NEXT(a_irq_tracks_state, s1_valid_r && s1_adv,
    out_irq_out == irq_now, "irq result differs from register state")

endmodule
